FILE: sv/dsu_pkg.sv
// Shared types, constants and tables for the direction to shape uv block.
// No dependencies; every other file imports this package.
package dsu_pkg;

	localparam int UV_BITS_DEF     = 16;
	localparam int QUEUE_DEPTH_DEF = 4;

	localparam int COORD_W      = 16;
	localparam int MAG_W        = 17;
	localparam int SUM_W        = 32;
	localparam int CORDIC_W     = 34;
	localparam int ANG_W        = 34;
	localparam int CORDIC_STEPS = 30;
	localparam int SQRT_W       = 60;
	localparam int SQRT_STEPS   = 30;
	localparam int ROOT_W       = 30;
	localparam int QUOT_W       = 32;
	localparam int REM_W        = 19;
	localparam int Q_W          = 36;
	localparam int PC_W         = 33;

	localparam logic signed [ANG_W-1:0] ANG_HALF    = 34'sd2147483648;
	localparam logic signed [ANG_W-1:0] ANG_QUARTER = 34'sd1073741824;

	localparam logic [2:0] MODE_SPHERE = 3'd0;
	localparam logic [2:0] MODE_CUBE   = 3'd1;
	localparam logic [2:0] MODE_OCTA   = 3'd2;
	localparam logic [2:0] MODE_CYL    = 3'd3;
	localparam logic [2:0] MODE_HEX    = 3'd4;
	localparam logic [2:0] MODE_TRI    = 3'd5;

	typedef enum logic [2:0] {
		CLS_SPHERE,
		CLS_RATIO,
		CLS_CYL,
		CLS_HEX,
		CLS_TRI
	} class_t;

	typedef struct packed {
		class_t                    cls;
		logic                      centered;
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
		logic signed [COORD_W-1:0] z;
		logic [SUM_W-1:0]          sq_sum;
		logic                      neg_u;
		logic                      neg_v;
		logic [MAG_W-1:0]          mag_u;
		logic [MAG_W-1:0]          mag_v;
		logic [MAG_W-1:0]          den;
	} item_t;

	// arctan(2^-i) in binary angle units, 2^32 per turn
	function automatic logic signed [ANG_W-1:0] turn_angle(input int unsigned i);
		logic signed [ANG_W-1:0] a;
		unique case (i)
			0:  a = 34'sh020000000;
			1:  a = 34'sh012E4051D;
			2:  a = 34'sh009FB385B;
			3:  a = 34'sh0051111D4;
			4:  a = 34'sh0028B0D43;
			5:  a = 34'sh00145D7E1;
			6:  a = 34'sh000A2F61E;
			7:  a = 34'sh000517C55;
			8:  a = 34'sh00028BE53;
			9:  a = 34'sh000145F2E;
			10: a = 34'sh0000A2F98;
			11: a = 34'sh0000517CC;
			12: a = 34'sh000028BE6;
			13: a = 34'sh0000145F3;
			14: a = 34'sh00000A2F9;
			15: a = 34'sh00000517C;
			16: a = 34'sh0000028BE;
			17: a = 34'sh00000145F;
			18: a = 34'sh000000A2F;
			19: a = 34'sh000000517;
			20: a = 34'sh00000028B;
			21: a = 34'sh000000145;
			22: a = 34'sh0000000A2;
			23: a = 34'sh000000051;
			24: a = 34'sh000000028;
			25: a = 34'sh000000014;
			26: a = 34'sh00000000A;
			27: a = 34'sh000000005;
			28: a = 34'sh000000002;
			29: a = 34'sh000000001;
			default: a = '0;
		endcase
		return a;
	endfunction

	// Q0.32 center of sector k for six (hex) or three (triangle) sectors
	function automatic logic [PC_W-1:0] prism_center(input logic tri_sel, input logic [2:0] k);
		logic [PC_W-1:0] c;
		if (tri_sel) begin
			unique case (k)
				3'd0:    c = 33'd715827883;
				3'd1:    c = 33'd2147483648;
				default: c = 33'd3579139413;
			endcase
		end else begin
			unique case (k)
				3'd0:    c = 33'd357913941;
				3'd1:    c = 33'd1073741824;
				3'd2:    c = 33'd1789569707;
				3'd3:    c = 33'd2505397589;
				3'd4:    c = 33'd3221225472;
				default: c = 33'd3937053355;
			endcase
		end
		return c;
	endfunction

endpackage

FILE: sv/direction_to_shape_uv.sv
// Direction to shape uv: maps a 3D direction to texture coordinates for one envelope shape.
// Top level; depends on dsu_pkg, dsu_front, dsu_queue and dsu_back.
//
// Input stream s_axis: tdata carries dir_x, dir_y, dir_z (signed Q1.14), one direction
// per transfer. Output stream m_axis: tdata carries u_coord, v_coord (Q0.UV_BITS).
// Every input transfer yields exactly one output transfer, in order.
// shape_mode is written through cfg_we/cfg_wdata while the block is idle:
// 0 sphere, 1 cube, 2 octahedron, 3 cylinder, 4 hex prism, 5 triangle prism,
// 6 and 7 act as sphere.
// Throughput: one direction per cycle while m_axis does not stall. The pipelines in
// series are the queue, azimuth CORDIC, square root, elevation CORDIC, ratio divider
// and output register. A stall on m_axis holds the whole back pipeline; the queue
// keeps taking input until it fills, then s_axis_tready drops.
// Reset clears the queue, all valid bits and sets shape_mode to sphere.
module direction_to_shape_uv import dsu_pkg::*; #(
	parameter int UV_BITS     = UV_BITS_DEF,
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_wdata,       // shape_mode
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [47:0] s_axis_tdata,    // dir_x, dir_y, dir_z
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata     // u_coord, v_coord
);

	item_t front_item, head_item;
	logic  q_full, q_nonempty, q_pop, q_push;

	dsu_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.tdata    (s_axis_tdata),
		.item     (front_item)
	);

	assign s_axis_tready = !q_full;
	assign q_push        = s_axis_tvalid && !q_full;

	dsu_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_item(front_item),
		.full     (q_full),
		.pop      (q_pop),
		.nonempty (q_nonempty),
		.head     (head_item)
	);

	dsu_back #(.UV_BITS(UV_BITS)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (q_nonempty),
		.in_item   (head_item),
		.in_pop    (q_pop),
		.out_tvalid(m_axis_tvalid),
		.out_tready(m_axis_tready),
		.out_tdata (m_axis_tdata)
	);

endmodule

FILE: sv/dsu_front.sv
// Front end: holds the shape register and classifies each direction into an item_t.
// Depends on dsu_pkg.
module dsu_front import dsu_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_wdata,
	input  logic [47:0] tdata,     // dir_x, dir_y, dir_z
	output item_t       item
);

	logic [2:0] shape_mode_q;
	logic signed [COORD_W-1:0] x, y, z;
	logic signed [MAG_W-1:0] xe, ye, ze;
	logic [MAG_W-1:0] ax, ay, az, m, l;
	logic signed [SUM_W-1:0] px, pz;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shape_mode_q <= MODE_SPHERE;
		end else if (cfg_we) begin
			shape_mode_q <= cfg_wdata;
		end
	end

	assign x  = tdata[15:0];
	assign y  = tdata[31:16];
	assign z  = tdata[47:32];
	assign xe = MAG_W'(x);
	assign ye = MAG_W'(y);
	assign ze = MAG_W'(z);
	assign ax = (xe < 0) ? -xe : xe;
	assign ay = (ye < 0) ? -ye : ye;
	assign az = (ze < 0) ? -ze : ze;
	assign px = x * x;
	assign pz = z * z;

	always_comb begin
		m = (ax > ay) ? ax : ay;
		if (az > m) begin
			m = az;
		end
		l = ax + ay + az;

		item          = '0;
		item.x        = x;
		item.y        = y;
		item.z        = z;
		item.sq_sum   = SUM_W'(px) + SUM_W'(pz);
		item.cls      = CLS_SPHERE;

		unique case (shape_mode_q)
			MODE_CUBE: begin
				item.cls      = CLS_RATIO;
				item.den      = m;
				item.centered = (m == '0);
				priority if (ax >= ay && ax >= az) begin
					item.neg_u = (x > 0) ? (z > 0) : (z < 0);
					item.mag_u = az;
					item.neg_v = (y < 0);
					item.mag_v = ay;
				end else if (ay >= az) begin
					item.neg_u = (x < 0);
					item.mag_u = ax;
					item.neg_v = (y > 0) ? (z > 0) : (z < 0);
					item.mag_v = az;
				end else begin
					item.neg_u = (z > 0) ? (x < 0) : (x > 0);
					item.mag_u = ax;
					item.neg_v = (y < 0);
					item.mag_v = ay;
				end
			end
			MODE_OCTA: begin
				item.cls      = CLS_RATIO;
				item.den      = l;
				item.centered = (l == '0);
				item.neg_u    = (x < 0);
				item.neg_v    = (y < 0);
				// fold the lower hemisphere out to the corners
				if (z < 0) begin
					item.mag_u = l - ay;
					item.mag_v = l - ax;
				end else begin
					item.mag_u = ax;
					item.mag_v = ay;
				end
			end
			MODE_CYL: item.cls = CLS_CYL;
			MODE_HEX: item.cls = CLS_HEX;
			MODE_TRI: item.cls = CLS_TRI;
			default:  item.cls = CLS_SPHERE;
		endcase
	end

endmodule

FILE: sv/dsu_queue.sv
// Short register queue that decouples the front end from the back end.
// Depends on dsu_pkg for item_t.
module dsu_queue import dsu_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  item_t push_item,
	output logic  full,
	input  logic  pop,
	output logic  nonempty,
	output item_t head
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	item_t entry_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;

	assign full     = (cnt_q == CNT_W'(DEPTH));
	assign nonempty = (cnt_q != '0);
	assign head     = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

FILE: sv/dsu_cordic.sv
// Pipelined vectoring CORDIC: binary angle of (x, y), one rotation per stage.
// Depends on dsu_pkg for the arctangent table; carries a side payload along.
module dsu_cordic import dsu_pkg::*; #(
	parameter int SIDE_W = 1
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       en,
	input  logic                       in_valid,
	input  logic signed [CORDIC_W-1:0] in_y,
	input  logic signed [CORDIC_W-1:0] in_x,
	input  logic [SIDE_W-1:0]          in_side,
	output logic                       out_valid,
	output logic signed [ANG_W-1:0]    out_ang,
	output logic [SIDE_W-1:0]          out_side
);

	logic signed [CORDIC_W-1:0] x_s   [CORDIC_STEPS];
	logic signed [CORDIC_W-1:0] y_s   [CORDIC_STEPS];
	logic signed [ANG_W-1:0]    acc_s [CORDIC_STEPS];
	logic                       done_s[CORDIC_STEPS];
	logic [SIDE_W-1:0]          side_s[CORDIC_STEPS];
	logic [CORDIC_STEPS-1:0]    vld_s;

	logic signed [CORDIC_W-1:0] px, py;
	logic signed [ANG_W-1:0]    pacc;
	logic                       pdone;
	logic signed [ANG_W-1:0]    last_acc;

	// axis cases are exact; the left half plane is turned by a half turn first
	always_comb begin
		px    = in_x;
		py    = in_y;
		pacc  = '0;
		pdone = 1'b0;
		priority if (in_y == 0) begin
			pdone = 1'b1;
			pacc  = (in_x < 0) ? ANG_HALF : '0;
		end else if (in_x == 0) begin
			pdone = 1'b1;
			pacc  = (in_y > 0) ? ANG_QUARTER : -ANG_QUARTER;
		end else if (in_x < 0) begin
			pacc = (in_y > 0) ? ANG_HALF : -ANG_HALF;
			px   = -in_x;
			py   = -in_y;
		end else begin
			pacc = '0;
		end
	end

	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
		logic signed [CORDIC_W-1:0] sx, sy;
		logic signed [ANG_W-1:0]    sacc;
		logic                       sdone;
		logic [SIDE_W-1:0]          sside;

		if (i == 0) begin : g_first
			assign sx    = px;
			assign sy    = py;
			assign sacc  = pacc;
			assign sdone = pdone;
			assign sside = in_side;
		end else begin : g_next
			assign sx    = x_s[i-1];
			assign sy    = y_s[i-1];
			assign sacc  = acc_s[i-1];
			assign sdone = done_s[i-1];
			assign sside = side_s[i-1];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				side_s[i] <= sside;
				done_s[i] <= sdone;
				if (sy > 0) begin
					x_s[i]   <= sx + (sy >>> i);
					y_s[i]   <= sy - (sx >>> i);
					acc_s[i] <= sdone ? sacc : sacc + turn_angle(i);
				end else begin
					x_s[i]   <= sx - (sy >>> i);
					y_s[i]   <= sy + (sx >>> i);
					acc_s[i] <= sdone ? sacc : sacc - turn_angle(i);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[CORDIC_STEPS-2:0], in_valid};
		end
	end

	assign last_acc  = acc_s[CORDIC_STEPS-1];
	assign out_valid = vld_s[CORDIC_STEPS-1];
	assign out_side  = side_s[CORDIC_STEPS-1];
	assign out_ang   = (last_acc > ANG_HALF)  ? ANG_HALF :
	                   (last_acc < -ANG_HALF) ? -ANG_HALF : last_acc;

endmodule

FILE: sv/dsu_isqrt.sv
// Pipelined integer square root, one result bit per stage.
// Depends on dsu_pkg; carries a side payload along.
module dsu_isqrt import dsu_pkg::*; #(
	parameter int SIDE_W = 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  logic [SQRT_W-1:0] in_n,
	input  logic [SIDE_W-1:0] in_side,
	output logic              out_valid,
	output logic [ROOT_W-1:0] out_root,
	output logic [SIDE_W-1:0] out_side
);

	logic [SQRT_W-1:0]     n_s   [SQRT_STEPS];
	logic [SQRT_W-1:0]     res_s [SQRT_STEPS];
	logic [SIDE_W-1:0]     side_s[SQRT_STEPS];
	logic [SQRT_STEPS-1:0] vld_s;

	for (genvar i = 0; i < SQRT_STEPS; i++) begin : g_step
		localparam logic [SQRT_W-1:0] BIT = SQRT_W'(1) << (2 * (SQRT_STEPS - 1 - i));
		logic [SQRT_W-1:0] sn, sres, trial;
		logic [SIDE_W-1:0] sside;

		if (i == 0) begin : g_first
			assign sn    = in_n;
			assign sres  = '0;
			assign sside = in_side;
		end else begin : g_next
			assign sn    = n_s[i-1];
			assign sres  = res_s[i-1];
			assign sside = side_s[i-1];
		end

		assign trial = sres + BIT;

		always_ff @(posedge clk) begin
			if (en) begin
				side_s[i] <= sside;
				if (sn >= trial) begin
					n_s[i]   <= sn - trial;
					res_s[i] <= (sres >> 1) + BIT;
				end else begin
					n_s[i]   <= sn;
					res_s[i] <= sres >> 1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[SQRT_STEPS-2:0], in_valid};
		end
	end

	assign out_valid = vld_s[SQRT_STEPS-1];
	assign out_root  = res_s[SQRT_STEPS-1][ROOT_W-1:0];
	assign out_side  = side_s[SQRT_STEPS-1];

endmodule

FILE: sv/dsu_div.sv
// Two-lane pipelined restoring divider for (mag * 2^32 + den) / (2 * den).
// Depends on dsu_pkg; both lanes share the divisor and a side payload.
module dsu_div import dsu_pkg::*; #(
	parameter int SIDE_W = 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  logic [MAG_W-1:0]  in_mag_u,
	input  logic [MAG_W-1:0]  in_mag_v,
	input  logic [MAG_W-1:0]  in_den,
	input  logic [SIDE_W-1:0] in_side,
	output logic              out_valid,
	output logic [QUOT_W-1:0] out_q_u,
	output logic [QUOT_W-1:0] out_q_v,
	output logic [SIDE_W-1:0] out_side
);

	logic [REM_W-1:0]  ru_s  [QUOT_W];
	logic [REM_W-1:0]  rv_s  [QUOT_W];
	logic [QUOT_W-1:0] qu_s  [QUOT_W];
	logic [QUOT_W-1:0] qv_s  [QUOT_W];
	logic [MAG_W-1:0]  den_s [QUOT_W];
	logic [SIDE_W-1:0] side_s[QUOT_W];
	logic [QUOT_W-1:0] vld_s;

	for (genvar i = 0; i < QUOT_W; i++) begin : g_step
		localparam int BI = QUOT_W - 1 - i;
		logic [REM_W-1:0]  sru, srv, tu, tv, dvs;
		logic [QUOT_W-1:0] squ, sqv;
		logic [MAG_W-1:0]  sden;
		logic [SIDE_W-1:0] sside;
		logic              sbit;

		if (i == 0) begin : g_first
			assign sru   = REM_W'(in_mag_u);
			assign srv   = REM_W'(in_mag_v);
			assign squ   = '0;
			assign sqv   = '0;
			assign sden  = in_den;
			assign sside = in_side;
		end else begin : g_next
			assign sru   = ru_s[i-1];
			assign srv   = rv_s[i-1];
			assign squ   = qu_s[i-1];
			assign sqv   = qv_s[i-1];
			assign sden  = den_s[i-1];
			assign sside = side_s[i-1];
		end

		// low dividend word is den itself
		if (BI < MAG_W) begin : g_bit
			assign sbit = sden[BI];
		end else begin : g_zero
			assign sbit = 1'b0;
		end

		assign dvs = REM_W'({sden, 1'b0});
		assign tu  = {sru[REM_W-2:0], sbit};
		assign tv  = {srv[REM_W-2:0], sbit};

		always_ff @(posedge clk) begin
			if (en) begin
				side_s[i] <= sside;
				den_s[i]  <= sden;
				if (tu >= dvs) begin
					ru_s[i] <= tu - dvs;
					qu_s[i] <= {squ[QUOT_W-2:0], 1'b1};
				end else begin
					ru_s[i] <= tu;
					qu_s[i] <= {squ[QUOT_W-2:0], 1'b0};
				end
				if (tv >= dvs) begin
					rv_s[i] <= tv - dvs;
					qv_s[i] <= {sqv[QUOT_W-2:0], 1'b1};
				end else begin
					rv_s[i] <= tv;
					qv_s[i] <= {sqv[QUOT_W-2:0], 1'b0};
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[QUOT_W-2:0], in_valid};
		end
	end

	assign out_valid = vld_s[QUOT_W-1];
	assign out_q_u   = qu_s[QUOT_W-1];
	assign out_q_v   = qv_s[QUOT_W-1];
	assign out_side  = side_s[QUOT_W-1];

endmodule

FILE: sv/dsu_back.sv
// Back end: angle, root and ratio pipelines, mode select, rounding and output register.
// Depends on dsu_pkg, dsu_cordic, dsu_isqrt and dsu_div.
module dsu_back import dsu_pkg::*; #(
	parameter int UV_BITS = UV_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  item_t       in_item,
	output logic        in_pop,
	output logic        out_tvalid,
	input  logic        out_tready,
	output logic [31:0] out_tdata
);

	localparam int IW  = $bits(item_t);
	localparam int W2  = IW + ANG_W;
	localparam int W4  = IW + 2 * ANG_W;

	logic en;
	logic out_valid_q;
	logic [31:0] out_data_q;

	logic v1, v2, v3, v4;
	logic signed [ANG_W-1:0] ang_a, ang_b;
	logic [IW-1:0] side1;
	logic [W2-1:0] side2, side3;
	logic [W4-1:0] side4;
	logic [ROOT_W-1:0] root;
	logic [QUOT_W-1:0] q_u, q_v;
	item_t it2, it3, itd, it;
	logic signed [ANG_W-1:0] ang_u, ang_v;

	logic signed [Q_W-1:0] cyl_u, cyl_v, sph_v, rat_u, rat_v, pri_u, qu, qv;
	logic [PC_W-1:0] cu;
	logic [Q_W-1:0] p6, p3;
	logic [2:0] k6, k3;

	assign en     = !out_valid_q || out_tready;
	assign in_pop = en && in_valid;

	dsu_cordic #(.SIDE_W(IW)) u_cordic_u (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (in_valid),
		.in_y     ({{(CORDIC_W - 30){in_item.z[15]}}, in_item.z, 14'b0}),
		.in_x     ({{(CORDIC_W - 30){in_item.x[15]}}, in_item.x, 14'b0}),
		.in_side  (in_item),
		.out_valid(v1),
		.out_ang  (ang_a),
		.out_side (side1)
	);

	dsu_isqrt #(.SIDE_W(W2)) u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (v1),
		.in_n     ({it2.sq_sum, 28'b0}),
		.in_side  ({ang_a, side1}),
		.out_valid(v2),
		.out_root (root),
		.out_side (side2)
	);

	assign it2 = item_t'(side1);
	assign it3 = item_t'(side2[IW-1:0]);
	assign itd = item_t'(side3[IW-1:0]);

	dsu_cordic #(.SIDE_W(W2)) u_cordic_v (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (v2),
		.in_y     ({{(CORDIC_W - 30){it3.y[15]}}, it3.y, 14'b0}),
		.in_x     (CORDIC_W'(root)),
		.in_side  (side2),
		.out_valid(v3),
		.out_ang  (ang_b),
		.out_side (side3)
	);

	dsu_div #(.SIDE_W(W4)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (v3),
		.in_mag_u (itd.mag_u),
		.in_mag_v (itd.mag_v),
		.in_den   (itd.den),
		.in_side  ({ang_b, side3}),
		.out_valid(v4),
		.out_q_u  (q_u),
		.out_q_v  (q_v),
		.out_side (side4)
	);

	assign it    = item_t'(side4[IW-1:0]);
	assign ang_u = side4[IW +: ANG_W];
	assign ang_v = side4[IW + ANG_W +: ANG_W];

	function automatic logic [15:0] to_uv(input logic signed [Q_W-1:0] q);
		logic [PC_W-1:0] qc;
		logic [PC_W:0]   s, r;
		logic [PC_W:0]   top;
		top = ((PC_W + 1)'(1) << UV_BITS) - 1'b1;
		if (q < 0) begin
			qc = '0;
		end else if (q > Q_W'(64'sd4294967296)) begin
			qc = PC_W'(64'd4294967296);
		end else begin
			qc = q[PC_W-1:0];
		end
		s = {1'b0, qc} + ((PC_W + 1)'(1) << (31 - UV_BITS));
		r = s >> (32 - UV_BITS);
		if (r > top) begin
			r = top;
		end
		return r[15:0];
	endfunction

	always_comb begin
		cyl_u = Q_W'(ang_u) + Q_W'(ANG_HALF);
		cyl_v = (Q_W'(it.y) <<< 17) + Q_W'(ANG_HALF);
		sph_v = (Q_W'(ang_v) <<< 1) + Q_W'(ANG_HALF);
		rat_u = it.neg_u ? Q_W'(ANG_HALF) - Q_W'(q_u) : Q_W'(ANG_HALF) + Q_W'(q_u);
		rat_v = it.neg_v ? Q_W'(ANG_HALF) - Q_W'(q_v) : Q_W'(ANG_HALF) + Q_W'(q_v);

		// sector index: floor(u * n), the seam goes to the last sector
		cu = cyl_u[PC_W-1:0];
		p6 = Q_W'({cu, 2'b00}) + Q_W'({cu, 1'b0});
		p3 = Q_W'({cu, 1'b0}) + Q_W'(cu);
		k6 = (p6[35:32] > 4'd5) ? 3'd5 : p6[34:32];
		k3 = (p3[35:32] > 4'd2) ? 3'd2 : p3[34:32];

		unique case (it.cls)
			CLS_RATIO: begin
				qu = it.centered ? Q_W'(ANG_HALF) : rat_u;
				qv = it.centered ? Q_W'(ANG_HALF) : rat_v;
			end
			CLS_CYL: begin
				qu = cyl_u;
				qv = cyl_v;
			end
			CLS_HEX: begin
				qu = Q_W'(prism_center(1'b0, k6));
				qv = cyl_v;
			end
			CLS_TRI: begin
				qu = Q_W'(prism_center(1'b1, k3));
				qv = cyl_v;
			end
			default: begin
				qu = cyl_u;
				qv = sph_v;
			end
		endcase
		pri_u = qu;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= v4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_data_q <= {to_uv(qv), to_uv(pri_u)};
		end
	end

	assign out_tvalid = out_valid_q;
	assign out_tdata  = out_data_q;

endmodule

FILE: verif/direction_to_shape_uv_test.sv
// Self-checking bench for direction_to_shape_uv: streams directions in every shape mode
// and checks each (u, v) against an in-bench bit-exact model. Depends on dsu_pkg and the RTL.
module direction_to_shape_uv_test;
	import dsu_pkg::*;

	localparam longint HALF = 64'sd2147483648;
	localparam longint QUARTER = 64'sd1073741824;
	localparam longint ONE_Q32 = 64'sd4294967296;
	localparam int CYCLE_LIMIT = 600000;
	localparam int DRAIN_CYCLES = 150;

	typedef enum logic [1:0] {
		ENT_DIR,
		ENT_MODE,
		ENT_WAIT
	} entry_kind_t;

	typedef struct {
		entry_kind_t kind;
		logic [2:0]  mode;
		logic [47:0] dirs;
		int          gap;
	} entry_t;

	typedef struct {
		logic [15:0] u;
		logic [15:0] v;
	} uv_t;

	localparam longint ATAN_STEP [30] = '{
		64'h20000000, 64'h12E4051D, 64'h09FB385B, 64'h051111D4, 64'h028B0D43,
		64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2E,
		64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3, 64'h0000A2F9,
		64'h0000517C, 64'h000028BE, 64'h0000145F, 64'h00000A2F, 64'h00000517,
		64'h0000028B, 64'h00000145, 64'h000000A2, 64'h00000051, 64'h00000028,
		64'h00000014, 64'h0000000A, 64'h00000005, 64'h00000002, 64'h00000001
	};

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [2:0]  cfg_wdata;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [47:0] s_axis_tdata;    // dir_x, dir_y, dir_z
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [31:0] m_axis_tdata;    // u_coord, v_coord

	entry_t pending_dirs[$];
	uv_t    expected_uv[$];
	logic [2:0] shape_sel;
	bit     in_taken;
	int     gap_left;
	int     stall_left;
	bit     long_hold_done;
	int     errors;
	int     cycles;
	int     dirs_sent;
	int     uv_checked;
	int     per_mode[8];

	direction_to_shape_uv dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	always #5 clk = ~clk;

	// binary angle of (x, y), 2^32 per turn, 30-step vectoring CORDIC
	function automatic longint bin_angle(longint y, longint x);
		longint acc;
		longint sx;
		longint sy;
		acc = 0;
		if (y == 0)
			return (x < 0) ? HALF : 0;
		if (x == 0)
			return (y > 0) ? QUARTER : -QUARTER;
		if (x < 0) begin
			acc = (y > 0) ? HALF : -HALF;
			x = -x;
			y = -y;
		end
		for (int i = 0; i < 30; i++) begin
			sx = x >>> i;
			sy = y >>> i;
			if (y > 0) begin
				x += sy;
				y -= sx;
				acc += ATAN_STEP[i];
			end else begin
				x -= sy;
				y += sx;
				acc -= ATAN_STEP[i];
			end
		end
		if (acc > HALF) acc = HALF;
		if (acc < -HALF) acc = -HALF;
		return acc;
	endfunction

	function automatic longint unsigned int_sqrt(longint unsigned n);
		longint unsigned res;
		longint unsigned b;
		res = 0;
		b = 64'd1 << 62;
		while (b > n)
			b >>= 2;
		while (b != 0) begin
			if (n >= res + b) begin
				n -= res + b;
				res = (res >> 1) + b;
			end else begin
				res >>= 1;
			end
			b >>= 2;
		end
		return res;
	endfunction

	// Q0.32 of (num/den + 1)/2, rounded
	function automatic longint ratio_q32(longint num, longint den);
		longint mag;
		mag = (((num < 0) ? -num : num) * ONE_Q32 + den) / (2 * den);
		return (num < 0) ? HALF - mag : HALF + mag;
	endfunction

	function automatic logic [15:0] q32_to_code(longint q);
		longint r;
		if (q < 0) q = 0;
		if (q > ONE_Q32) q = ONE_Q32;
		r = (q + (64'sd1 << 15)) >>> 16;
		if (r > 65535) r = 65535;
		return r[15:0];
	endfunction

	function automatic uv_t map_direction(logic [2:0] mode, logic [47:0] d);
		longint x, y, z, ax, ay, az, qu, qv, cu, cv, m, l, nx, ny, r;
		longint unsigned n, k;
		uv_t res;
		x = longint'($signed(d[15:0]));
		y = longint'($signed(d[31:16]));
		z = longint'($signed(d[47:32]));
		ax = (x < 0) ? -x : x;
		ay = (y < 0) ? -y : y;
		az = (z < 0) ? -z : z;
		qu = HALF;
		qv = HALF;
		cu = bin_angle(z * 16384, x * 16384) + HALF;
		cv = y * 131072 + HALF;
		case (mode)
			MODE_CUBE: begin
				m = (ax > ay) ? ax : ay;
				if (az > m) m = az;
				if (m != 0) begin
					if (ax >= ay && ax >= az) begin
						qu = ratio_q32((x > 0) ? -z : z, m);
						qv = ratio_q32(y, m);
					end else if (ay >= az) begin
						qu = ratio_q32(x, m);
						qv = ratio_q32((y > 0) ? -z : z, m);
					end else begin
						qu = ratio_q32((z > 0) ? x : -x, m);
						qv = ratio_q32(y, m);
					end
				end
			end
			MODE_OCTA: begin
				l = ax + ay + az;
				nx = x;
				ny = y;
				if (l != 0) begin
					// fold the lower hemisphere outward
					if (z < 0) begin
						nx = (x >= 0) ? (l - ay) : -(l - ay);
						ny = (y >= 0) ? (l - ax) : -(l - ax);
					end
					qu = ratio_q32(nx, l);
					qv = ratio_q32(ny, l);
				end
			end
			MODE_CYL: begin
				qu = cu;
				qv = cv;
			end
			MODE_HEX, MODE_TRI: begin
				n = (mode == MODE_HEX) ? 6 : 3;
				k = (longint'(unsigned'(cu)) * n) >> 32;
				if (k > n - 1) k = n - 1;
				qu = longint'((((2 * k + 1) << 32) + n) / (2 * n));
				qv = cv;
			end
			default: begin
				r = longint'(int_sqrt(longint'(unsigned'(x * x + z * z)) << 28));
				qu = cu;
				qv = 2 * bin_angle(y * 16384, r) + HALF;
			end
		endcase
		res.u = q32_to_code(qu);
		res.v = q32_to_code(qv);
		return res;
	endfunction

	function automatic logic [47:0] pack_dir(int x, int y, int z);
		logic [15:0] a, b, c;
		a = x[15:0];
		b = y[15:0];
		c = z[15:0];
		return {c, b, a};
	endfunction

	function automatic int pick_gap(bit burst);
		int p;
		p = $urandom_range(99);
		if (burst || p < 65) return 0;
		if (p < 95) return $urandom_range(3, 1);
		return $urandom_range(40, 10);
	endfunction

	function automatic int rand_comp(int style);
		case (style)
			0: return $signed(16'($urandom));
			1: return $urandom_range(64) - 32;
			2: return ($urandom_range(1)) ? -32768 : 32767;
			default: return $urandom_range(32768) - 16384;
		endcase
	endfunction

	task automatic add_mode(logic [2:0] mode);
		entry_t e;
		e.kind = ENT_MODE;
		e.mode = mode;
		e.dirs = '0;
		e.gap = 0;
		pending_dirs.push_back(e);
	endtask

	task automatic add_dir(logic [47:0] d, int gap);
		entry_t e;
		e.kind = ENT_DIR;
		e.mode = '0;
		e.dirs = d;
		e.gap = gap;
		pending_dirs.push_back(e);
	endtask

	// sender
	always @(negedge clk) begin
		entry_t e;
		bit we;
		if (arst_n) begin
			we = 1'b0;
			if (s_axis_tvalid && !in_taken) begin
				// hold the offered transfer
			end else if (gap_left > 0) begin
				gap_left <= gap_left - 1;
				s_axis_tvalid <= 1'b0;
			end else if (pending_dirs.size() == 0) begin
				s_axis_tvalid <= 1'b0;
			end else begin
				e = pending_dirs[0];
				case (e.kind)
					ENT_DIR: begin
						s_axis_tvalid <= 1'b1;
						s_axis_tdata <= e.dirs;
						gap_left <= e.gap;
						void'(pending_dirs.pop_front());
					end
					ENT_MODE: begin
						s_axis_tvalid <= 1'b0;
						if (expected_uv.size() == 0) begin
							we = 1'b1;
							cfg_wdata <= e.mode;
							shape_sel = e.mode;
							void'(pending_dirs.pop_front());
						end
					end
					default: begin
						s_axis_tvalid <= 1'b0;
						if (expected_uv.size() == 0)
							void'(pending_dirs.pop_front());
					end
				endcase
			end
			cfg_we <= we;
			in_taken = 1'b0;
		end
	end

	// receiver, with one long hold-off to back the block up
	always @(negedge clk) begin
		int p;
		if (arst_n) begin
			p = $urandom_range(99);
			if (stall_left > 0) begin
				stall_left <= stall_left - 1;
				m_axis_tready <= 1'b0;
			end else if (!long_hold_done && dirs_sent >= 240) begin
				long_hold_done <= 1'b1;
				stall_left <= 400;
				m_axis_tready <= 1'b0;
			end else if (p < 75) begin
				m_axis_tready <= 1'b1;
			end else begin
				stall_left <= (p < 97) ? $urandom_range(3) : $urandom_range(40, 10);
				m_axis_tready <= 1'b0;
			end
		end
	end

	// input and output monitor
	always @(posedge clk) begin
		uv_t want;
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("%0t: timeout with %0d results outstanding", $time, expected_uv.size());
			$display("direction_to_shape_uv_test NOT OK");
			$finish;
		end
		if (arst_n && s_axis_tvalid && s_axis_tready) begin
			expected_uv.push_back(map_direction(shape_sel, s_axis_tdata));
			per_mode[shape_sel] = per_mode[shape_sel] + 1;
			dirs_sent = dirs_sent + 1;
			in_taken = 1'b1;
		end
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (expected_uv.size() == 0) begin
				errors = errors + 1;
				$display("%0t: unexpected transfer, actual u=%0d v=%0d", $time,
					m_axis_tdata[15:0], m_axis_tdata[31:16]);
			end else begin
				want = expected_uv.pop_front();
				if (m_axis_tdata[15:0] !== want.u) begin
					errors = errors + 1;
					$display("%0t: u_coord expected %0d actual %0d", $time, want.u,
						m_axis_tdata[15:0]);
				end
				if (m_axis_tdata[31:16] !== want.v) begin
					errors = errors + 1;
					$display("%0t: v_coord expected %0d actual %0d", $time, want.v,
						m_axis_tdata[31:16]);
				end
			end
			uv_checked = uv_checked + 1;
		end
	end

	initial begin
		int dx[16] = '{0, 16384, -16384, 0, 0, 0, 0, 32767, -32768, 5000, 7000, -9000,
			-12, 40, 3, 32767};
		int dy[16] = '{0, 0, 0, 16384, -16384, 0, 0, 32767, -32768, 5000, 7000, 9000,
			0, -40, -3, -32768};
		int dz[16] = '{0, 0, 0, 0, 0, 16384, -16384, 32767, -32768, -200, 7000, 9000,
			0, 100, -7, 0};
		int style;
		bit burst;
		logic [2:0] mode;
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		m_axis_tready = 1'b0;
		shape_sel = MODE_SPHERE;
		in_taken = 1'b0;
		gap_left = 0;
		stall_left = 0;
		long_hold_done = 1'b0;
		errors = 0;
		cycles = 0;
		dirs_sent = 0;
		uv_checked = 0;
		foreach (per_mode[i]) per_mode[i] = 0;

		// directed: axes, zero, extremes, ties, every mode including the spare codes
		for (int md = 0; md < 8; md++) begin
			add_mode(3'(md));
			for (int i = 0; i < 16; i++)
				if (md < 6 || i < 4)
					add_dir(pack_dir(dx[i], dy[i], dz[i]), 0);
		end

		// random phases with a mode change between them
		for (int ph = 0; ph < 14; ph++) begin
			mode = (ph == 0) ? 3'd5 : (ph == 1) ? 3'd0 : 3'($urandom_range(7));
			add_mode(mode);
			burst = (ph % 4 == 2);
			for (int i = 0; i < 93; i++) begin
				style = $urandom_range(9);
				if (style < 6)
					add_dir(pack_dir(rand_comp(0), rand_comp(0), rand_comp(0)),
						pick_gap(burst));
				else if (style == 6)
					add_dir(pack_dir(rand_comp(1), rand_comp(1), rand_comp(1)),
						pick_gap(burst));
				else if (style == 7)
					add_dir(pack_dir(rand_comp(2), rand_comp(3), rand_comp(2)),
						pick_gap(burst));
				else begin
					// ties and single-axis directions
					style = rand_comp(0);
					add_dir(pack_dir(style, $urandom_range(1) ? style : 0,
						$urandom_range(1) ? -style : 0), pick_gap(burst));
				end
			end
			if (ph % 5 == 3) begin
				pending_dirs.push_back('{ENT_WAIT, 3'd0, 48'd0, 0});
			end
		end
		add_mode(MODE_SPHERE);

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		wait (pending_dirs.size() == 0 && !s_axis_tvalid);
		wait (expected_uv.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Sent %0d directions, checked %0d results", dirs_sent, uv_checked);
		$display("Per mode 0..7: %0d %0d %0d %0d %0d %0d %0d %0d",
			per_mode[0], per_mode[1], per_mode[2], per_mode[3],
			per_mode[4], per_mode[5], per_mode[6], per_mode[7]);
		$display("Covered all shape modes, axis, zero and extreme directions, both-side stalls.");
		if (errors == 0 && expected_uv.size() == 0) begin
			$display("direction_to_shape_uv_test OK");
		end else begin
			$display("direction_to_shape_uv_test NOT OK");
		end
		$finish;
	end

endmodule

FILE: files.f
sv/dsu_pkg.sv
sv/dsu_front.sv
sv/dsu_queue.sv
sv/dsu_cordic.sv
sv/dsu_isqrt.sv
sv/dsu_div.sv
sv/dsu_back.sv
sv/direction_to_shape_uv.sv
verif/direction_to_shape_uv_test.sv
